// ----- hdl/thq_pkg.sv -----
// thq_pkg: shared types and codes for the terrain height query block
`timescale 1ns / 1ps
package thq_pkg;
  // item modes
  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_BOX    = 2'd1;
  localparam logic [1:0] MODE_CELL   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GROUND    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE = 3'd3;
  localparam logic [2:0] REG_GRID_W    = 3'd4;
  localparam logic [2:0] REG_GRID_H    = 3'd5;
  localparam logic [2:0] REG_UNKNOWN   = 3'd6;
  localparam logic [2:0] REG_THRESHOLD = 3'd7;

  localparam int DIV_STEPS = 32;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic wr_box;
    logic wr_cell;
    logic calc_idx;
    logic rd_grid;
    logic finish;
  } thq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic work_done;
  } thq_sts_t;

  // one stored box
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    logic signed [31:0] top;
  } thq_box_t;
endpackage

// ----- hdl/thq_if.sv -----
// thq_if: input and result channel interfaces
`timescale 1ns / 1ps
interface thq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic [11:0]        slot;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_top;
  logic [1:0]         box_flags;
  logic signed [31:0] cell_elevation;
  logic signed [7:0]  cell_occupancy;
  modport source (output valid, mode, query_x, query_y, slot, box_min_x, box_max_x,
                  box_min_y, box_max_y, box_top, box_flags, cell_elevation,
                  cell_occupancy, input ready);
  modport sink (input valid, mode, query_x, query_y, slot, box_min_x, box_max_x,
                box_min_y, box_max_y, box_top, box_flags, cell_elevation,
                cell_occupancy, output ready);
endinterface

interface thq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] terrain_height;
  logic               no_step;
  modport source (output valid, terrain_height, no_step, input ready);
  modport sink (input valid, terrain_height, no_step, output ready);
endinterface

// ----- hdl/terrain_height_and_no_step_query_top.sv -----
// terrain_height_and_no_step_query_top: top level of the terrain query block
//
// Input channel in_ch carries one item per transfer: mode selects a point
// query, a box slot write or a grid cell write. Writes take effect at the
// transfer and give no result; an unused mode is dropped. A query gives one
// result on out_ch: the highest surface at the point and the no-step flag.
// The configuration port writes register cfg_index with cfg_data when cfg_we
// is high; write it only while no query is in flight.
// A query runs through the two 32-step restoring dividers for the cell
// column and row, with the box table scan of one slot per cycle running
// alongside, then through states for the cell index, the map read and the
// result.
// One query is worked at a time; the next item is taken once the result is
// in the output register, which holds it while the receiver stalls; a
// stalled result holds up the following query only at its final cycle.
// Reset sets the threshold to 50 and clears the other configuration registers
// and box valid flags; box fields and grid cells are unset until written.
`timescale 1ns / 1ps
module terrain_height_and_no_step_query_top #(
  parameter int MAX_BOXES     = 16,
  parameter int GRID_CELLS    = 4096,
  parameter int MAX_GRID_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  thq_in_if.sink      in_ch,
  thq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import thq_pkg::*;

  thq_cmd_t cmd;
  thq_sts_t sts;

  // sequencing
  thq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and arithmetic
  thq_dp #(
    .MAX_BOXES     (MAX_BOXES),
    .GRID_CELLS    (GRID_CELLS),
    .MAX_GRID_SIDE (MAX_GRID_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .query_x        (in_ch.query_x),
    .query_y        (in_ch.query_y),
    .slot           (in_ch.slot),
    .box_min_x      (in_ch.box_min_x),
    .box_max_x      (in_ch.box_max_x),
    .box_min_y      (in_ch.box_min_y),
    .box_max_y      (in_ch.box_max_y),
    .box_top        (in_ch.box_top),
    .box_flags      (in_ch.box_flags),
    .cell_elevation (in_ch.cell_elevation),
    .cell_occupancy (in_ch.cell_occupancy),
    .terrain_height (out_ch.terrain_height),
    .no_step        (out_ch.no_step)
  );
endmodule

// ----- hdl/thq_ctrl.sv -----
// thq_ctrl: sequencing state machine for the terrain height query block
`timescale 1ns / 1ps
module thq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output thq_pkg::thq_cmd_t cmd,
  input  thq_pkg::thq_sts_t sts
);
  import thq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;
  logic       in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_mode)
            MODE_QUERY: begin
              cmd.start  = 1'b1;
              state_next = S_RUN;
            end
            MODE_BOX:  cmd.wr_box  = 1'b1;
            MODE_CELL: cmd.wr_cell = 1'b1;
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (sts.work_done) state_next = S_IDX;
      end
      S_IDX: begin
        cmd.calc_idx = 1'b1;
        state_next   = S_RD;
      end
      S_RD: begin
        cmd.rd_grid = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ----- hdl/thq_dp.sv -----
// thq_dp: box table, grid map, cell dividers and height accumulation
`timescale 1ns / 1ps
module thq_dp #(
  parameter int MAX_BOXES     = 16,
  parameter int GRID_CELLS    = 4096,
  parameter int MAX_GRID_SIDE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  thq_pkg::thq_cmd_t   cmd,
  output thq_pkg::thq_sts_t   sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  query_x,
  input  logic signed [31:0]  query_y,
  input  logic [11:0]         slot,
  input  logic signed [31:0]  box_min_x,
  input  logic signed [31:0]  box_max_x,
  input  logic signed [31:0]  box_min_y,
  input  logic signed [31:0]  box_max_y,
  input  logic signed [31:0]  box_top,
  input  logic [1:0]          box_flags,
  input  logic signed [31:0]  cell_elevation,
  input  logic signed [7:0]   cell_occupancy,
  output logic signed [31:0]  terrain_height,
  output logic                no_step
);
  import thq_pkg::*;

  localparam int BW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int PW  = $clog2(MAX_BOXES + 1);
  localparam int AW  = $clog2(GRID_CELLS);
  localparam int SW  = $clog2(MAX_GRID_SIDE + 1);
  localparam int IW  = 2 * SW + 1;
  localparam int CW  = $clog2(DIV_STEPS);

  // configuration registers
  logic signed [31:0] ground_height, grid_origin_x, grid_origin_y;
  logic [30:0]        cell_size;
  logic [6:0]         grid_width, grid_height, occ_level;
  logic               unknown_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_height  <= '0;
      grid_origin_x  <= '0;
      grid_origin_y  <= '0;
      cell_size      <= '0;
      grid_width     <= '0;
      grid_height    <= '0;
      unknown_blocks <= 1'b0;
      occ_level      <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUND:    ground_height  <= cfg_data;
        REG_ORIGIN_X:  grid_origin_x  <= cfg_data;
        REG_ORIGIN_Y:  grid_origin_y  <= cfg_data;
        REG_CELL_SIZE: cell_size      <= cfg_data[30:0];
        REG_GRID_W:    grid_width     <= cfg_data[6:0];
        REG_GRID_H:    grid_height    <= cfg_data[6:0];
        REG_UNKNOWN:   unknown_blocks <= cfg_data[0];
        REG_THRESHOLD: occ_level      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped grid extent
  logic [SW-1:0] gw, gh;
  always_comb begin
    gw = (32'(grid_width) > 32'(MAX_GRID_SIDE)) ? SW'(MAX_GRID_SIDE) : SW'(grid_width);
    gh = (32'(grid_height) > 32'(MAX_GRID_SIDE)) ? SW'(MAX_GRID_SIDE) : SW'(grid_height);
  end

  // box table: fields in memory, flags in flops
  thq_box_t box_mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] box_valid, box_forbid;
  logic box_wr_ok;
  assign box_wr_ok = 32'(slot) < 32'(MAX_BOXES);

  always_ff @(posedge clk) begin
    if (cmd.wr_box && box_wr_ok)
      box_mem[BW'(slot)] <= '{box_min_x, box_max_x, box_min_y, box_max_y, box_top};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid  <= '0;
      box_forbid <= '0;
    end else if (cmd.wr_box && box_wr_ok) begin
      box_valid[BW'(slot)]  <= box_flags[0];
      box_forbid[BW'(slot)] <= box_flags[1];
    end
  end

  // grid map memory
  logic [39:0] grid_mem [GRID_CELLS];
  logic [39:0] grid_rd;
  logic [AW-1:0] grid_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr_cell && (32'(slot) < 32'(GRID_CELLS)))
      grid_mem[AW'(slot)] <= {cell_elevation, cell_occupancy};
    if (cmd.rd_grid)
      grid_rd <= grid_mem[grid_addr];
  end

  // query point and origin offsets
  logic signed [31:0] qx, qy;
  logic signed [32:0] dx, dy;
  assign dx = {qx[31], qx} - {grid_origin_x[31], grid_origin_x};
  assign dy = {qy[31], qy} - {grid_origin_y[31], grid_origin_y};

  // two restoring dividers, one quotient bit per cycle
  logic [31:0] dvd_x, dvd_y, quo_x, quo_y;
  logic [30:0] rem_x, rem_y;
  logic [31:0] trial_x, trial_y;
  logic [CW-1:0] div_cnt;
  logic div_run;

  assign trial_x = {rem_x, dvd_x[31]};
  assign trial_y = {rem_y, dvd_y[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.start) begin
      div_run <= 1'b1;
      div_cnt <= '0;
    end else if (div_run) begin
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == CW'(DIV_STEPS - 1)) div_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx    <= query_x;
      qy    <= query_y;
      rem_x <= '0;
      rem_y <= '0;
      quo_x <= '0;
      quo_y <= '0;
    end else if (div_run) begin
      if (div_cnt == '0) begin
        dvd_x <= dx[31:0];
        dvd_y <= dy[31:0];
      end else begin
        dvd_x <= {dvd_x[30:0], 1'b0};
        dvd_y <= {dvd_y[30:0], 1'b0};
        if (trial_x >= {1'b0, cell_size}) begin
          rem_x <= 31'(trial_x - {1'b0, cell_size});
          quo_x <= {quo_x[30:0], 1'b1};
        end else begin
          rem_x <= trial_x[30:0];
          quo_x <= {quo_x[30:0], 1'b0};
        end
        if (trial_y >= {1'b0, cell_size}) begin
          rem_y <= 31'(trial_y - {1'b0, cell_size});
          quo_y <= {quo_y[30:0], 1'b1};
        end else begin
          rem_y <= trial_y[30:0];
          quo_y <= {quo_y[30:0], 1'b0};
        end
      end
    end
  end

  // final divider step, done in the cycle after the counter wraps
  logic div_tail;
  always_ff @(posedge clk) begin
    if (rst) div_tail <= 1'b0;
    else div_tail <= div_run && (div_cnt == CW'(DIV_STEPS - 1));
  end

  logic [31:0] col, row;
  always_comb begin
    col = {quo_x[30:0], trial_x >= {1'b0, cell_size}};
    row = {quo_y[30:0], trial_y >= {1'b0, cell_size}};
  end
  logic [31:0] col_q, row_q;
  always_ff @(posedge clk) begin
    if (div_tail) begin
      col_q <= col;
      row_q <= row;
    end
  end

  // box scan: one slot read per cycle, checked the cycle after
  logic [PW-1:0] bptr;
  logic          scan_run, brd_v;
  logic [BW-1:0] bslot_q;
  thq_box_t      brd;
  logic signed [31:0] hgt;
  logic          forb;
  logic          inside_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      brd_v    <= 1'b0;
      bptr     <= '0;
    end else if (cmd.start) begin
      scan_run <= 1'b1;
      brd_v    <= 1'b0;
      bptr     <= '0;
    end else begin
      brd_v <= scan_run;
      if (scan_run) begin
        bptr <= bptr + 1'b1;
        if (bptr == PW'(MAX_BOXES - 1)) scan_run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_run) begin
      brd     <= box_mem[BW'(bptr)];
      bslot_q <= BW'(bptr);
    end
  end

  assign inside_box = box_valid[bslot_q] &&
                      (qx >= brd.min_x) && (qx <= brd.max_x) &&
                      (qy >= brd.min_y) && (qy <= brd.max_y);

  assign sts.work_done = !scan_run && !brd_v && !div_run && !div_tail;

  // grid hit and cell index
  logic grid_on, grid_hit, hit_q;
  logic [IW-1:0] idx;
  assign grid_on = (gw != '0) && (gh != '0) && (cell_size != '0) &&
                   !dx[32] && !dy[32];
  assign idx = IW'(row_q[SW-1:0]) * IW'(gw) + IW'(col_q[SW-1:0]);
  assign grid_hit = grid_on && (col_q < 32'(gw)) && (row_q < 32'(gh)) &&
                    (32'(idx) < 32'(GRID_CELLS));

  always_ff @(posedge clk) begin
    if (cmd.calc_idx) begin
      grid_addr <= AW'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) hit_q <= 1'b0;
    else if (cmd.calc_idx) hit_q <= grid_hit;
  end

  // height and no-step accumulation
  logic signed [31:0] elev;
  logic signed [7:0]  occ;
  assign elev = grid_rd[39:8];
  assign occ  = grid_rd[7:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hgt  <= ground_height;
      forb <= 1'b0;
    end else if (brd_v && inside_box) begin
      if (brd.top > hgt) hgt <= brd.top;
      if (box_forbid[bslot_q]) forb <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      terrain_height <= (hit_q && elev > hgt) ? elev : hgt;
      if (forb || !hit_q) no_step <= forb;
      else if (occ < 0) no_step <= unknown_blocks;
      else no_step <= ({1'b0, occ[6:0]} >= {1'b0, occ_level});
    end
  end
endmodule
